// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/pblep_pkg.sv -----
// ----------------------------------------------------------------------------
// PolyBLEP oscillator package
// Shared constants, divider handshake types and the cosine table builder.
// ----------------------------------------------------------------------------
`default_nettype none
package pblep_pkg;
	localparam int PHASE_BITS = 24;
	localparam int TBL_BITS = 10;
	localparam int TBL_SIZE = 1 << TBL_BITS;
	localparam int OUT_BITS = 16;
	localparam int QUOT_BITS = 30;
	localparam int NUM_BITS = 23;

	localparam logic [1:0] WAVE_SAW = 2'd0;
	localparam logic [1:0] WAVE_PULSE = 2'd1;
	localparam logic [1:0] WAVE_SINE = 2'd2;
	localparam logic [1:0] WAVE_TRI = 2'd3;

	localparam longint Q30 = longint'(1) << 30;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint TAYLOR_DIV [12] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380,
		462, 552};

	typedef struct packed {
		logic start;
		logic [NUM_BITS-1:0] num;
		logic [NUM_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QUOT_BITS-1:0] quot;
	} div_rsp_t;

	typedef logic signed [OUT_BITS-1:0] cos_tbl_t [TBL_SIZE];

	function automatic int cos_mag(int m);
		longint a;
		longint term;
		longint sum;
		a = (longint'(m) * TWO_PI_Q30) >>> TBL_BITS;
		term = Q30;
		sum = Q30;
		for (int n = 0; n < 12; n++) begin
			term = (term * a) >>> 30;
			term = (term * a) >>> 30;
			term = term / TAYLOR_DIV[n];
			if ((n % 2) == 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > Q30) begin
			sum = Q30;
		end
		return int'((sum * 32767 + (longint'(1) << 29)) >>> 30);
	endfunction

	function automatic cos_tbl_t build_cos_tbl();
		cos_tbl_t tbl;
		int quarter;
		int q;
		int r;
		int v;
		quarter = TBL_SIZE / 4;
		for (int i = 0; i < TBL_SIZE; i++) begin
			q = i >> (TBL_BITS - 2);
			r = i & (quarter - 1);
			if (q == 0) begin
				v = cos_mag(r);
			end else if (q == 1) begin
				v = -cos_mag(quarter - r);
			end else if (q == 2) begin
				v = -cos_mag(r);
			end else begin
				v = cos_mag(quarter - r);
			end
			tbl[i] = OUT_BITS'(v);
		end
		return tbl;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/pblep_div.sv -----
// ----------------------------------------------------------------------------
// PolyBLEP divider
// Restoring divider, one quotient bit per cycle: (num << 30) / den, num < den.
// ----------------------------------------------------------------------------
`default_nettype none
module pblep_div
	import pblep_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);
	localparam logic [4:0] LAST_STEP = 5'(QUOT_BITS - 1);

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] den_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic [NUM_BITS:0] rem2;
	logic fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? NUM_BITS'(rem2 - {1'b0, den_q}) : rem2[NUM_BITS-1:0];
			quot_q <= {quot_q[QUOT_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule
`default_nettype wire

// ----- hw/rtl/pblep_rom.sv -----
// ----------------------------------------------------------------------------
// PolyBLEP cosine ROM
// Full-cycle cosine table, Q1.15, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pblep_rom
	import pblep_pkg::*;
(
	input wire logic clk,
	input wire logic [TBL_BITS-1:0] addr,
	output logic signed [OUT_BITS-1:0] data
);
	localparam cos_tbl_t COS_TBL = build_cos_tbl();

	always_ff @(posedge clk) begin
		data <= COS_TBL[addr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/polyblep_oscillator.sv -----
// ----------------------------------------------------------------------------
// PolyBLEP oscillator
// Band-limited saw, pulse, sine and triangle oscillator, one sample per tick.
// ----------------------------------------------------------------------------
// Each accepted tick produces one Q1.15 sample. Three BLEP terms are formed one
// after another on a single 30-step restoring divider and one shared squaring
// multiplier; a term whose phase lies away from an edge skips the divider, and
// the COMB, TRIMUL, TRIACC and FINISH states then combine the waves and update
// the triangle integrator. s_tready is high only while the sequencer is idle; a
// finished sample waits in the output register, and a stalled output holds the
// tick.
`default_nettype none
module polyblep_oscillator
	import pblep_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [47:0] s_tdata, // phase_increment[22:0], pulse_width[46:23]
	input wire logic [1:0] s_tuser, // wave_select[1:0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata // sample_out[15:0]
);
	`include "assert_macros.svh"

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SETUP = 9'b000000010,
		ST_DIV = 9'b000000100,
		ST_SQR = 9'b000001000,
		ST_STORE = 9'b000010000,
		ST_COMB = 9'b000100000,
		ST_TRIMUL = 9'b001000000,
		ST_TRIACC = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	localparam logic signed [33:0] Q30_S = 34'sd1073741824;
	localparam logic signed [33:0] RND15 = 34'sd16384;
	localparam logic signed [43:0] RND24 = 44'sd8388608;
	localparam logic [PHASE_BITS-1:0] PH_HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
	localparam logic signed [17:0] TRI_MAX = 18'sd131071;
	localparam logic signed [17:0] TRI_MIN = -18'sd131072;
	localparam logic signed [18:0] O_MAX = 19'sd32767;
	localparam logic signed [18:0] O_MIN = -19'sd32768;

	state_t state_q;
	logic [1:0] arg_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] t_q;
	logic [22:0] d_q;
	logic [PHASE_BITS-1:0] pw_q;
	logic [1:0] sel_q;
	logic casea_q;
	logic [30:0] u_q;
	logic [61:0] prod_q;
	logic signed [31:0] b_q [3];
	logic signed [33:0] v_q;
	logic signed [19:0] diff_q;
	logic signed [43:0] tprod_q;
	logic signed [17:0] z_q;
	logic m_tvalid_q;
	logic [15:0] m_tdata_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic signed [OUT_BITS-1:0] rom_data;

	logic [PHASE_BITS-1:0] arg_val;
	logic [PHASE_BITS:0] arg_sum;
	logic case_a;
	logic case_b;
	logic [PHASE_BITS-1:0] t_new;
	logic signed [33:0] b0_w;
	logic signed [33:0] b1_w;
	logic signed [33:0] b2_w;
	logic signed [33:0] saw_w;
	logic signed [33:0] pulse_w;
	logic signed [33:0] sq_w;
	logic signed [33:0] sq_rnd;
	logic signed [18:0] sq15_w;
	logic signed [43:0] tri_rnd;
	logic signed [20:0] z_sum;
	logic signed [33:0] o_rnd;
	logic signed [18:0] o_w;
	logic [15:0] o_fin;
	logic out_free;
	logic [31:0] sq_mag;

	pblep_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	pblep_rom u_rom (
		.clk(clk),
		.addr(t_q[PHASE_BITS-1 -: TBL_BITS]),
		.data(rom_data)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign t_new = phase_q + PHASE_BITS'(s_tdata[22:0]);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		unique case (arg_q)
			2'd0: arg_val = t_q;
			2'd1: arg_val = t_q - pw_q;
			default: arg_val = t_q ^ PH_HALF;
		endcase
	end

	assign arg_sum = {1'b0, arg_val} + {2'b0, d_q};
	assign case_a = arg_val < {1'b0, d_q};
	assign case_b = arg_sum > {1'b1, {PHASE_BITS{1'b0}}};

	assign div_req.start = (state_q == ST_SETUP) && (case_a || case_b);
	assign div_req.num = case_a ? arg_val[22:0] : arg_sum[22:0];
	assign div_req.den = d_q;

	assign sq_mag = prod_q[61:30];

	assign b0_w = 34'(b_q[0]);
	assign b1_w = 34'(b_q[1]);
	assign b2_w = 34'(b_q[2]);
	assign saw_w = $signed({3'b000, t_q, 7'b0000000}) - Q30_S - b0_w;
	assign pulse_w = ((t_q > pw_q) ? Q30_S : -Q30_S) - b0_w + b1_w;
	assign sq_w = ((t_q > PH_HALF) ? Q30_S : -Q30_S) - b0_w + b2_w;
	assign sq_rnd = sq_w + RND15;
	assign sq15_w = sq_rnd[33:15];

	assign tri_rnd = tprod_q + RND24;
	assign z_sum = 21'(z_q) + 21'($signed(tri_rnd[43:24]));

	assign o_rnd = v_q + RND15;
	assign o_w = o_rnd[33:15];

	always_comb begin
		unique case (sel_q)
			WAVE_SAW, WAVE_PULSE: begin
				if (o_w > O_MAX) begin
					o_fin = 16'(O_MAX);
				end else if (o_w < O_MIN) begin
					o_fin = 16'(O_MIN);
				end else begin
					o_fin = o_w[15:0];
				end
			end
			WAVE_SINE: o_fin = rom_data;
			default: begin
				if (z_q > 18'(O_MAX)) begin
					o_fin = 16'(O_MAX);
				end else if (z_q < 18'(O_MIN)) begin
					o_fin = 16'(O_MIN);
				end else begin
					o_fin = z_q[15:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			arg_q <= '0;
			phase_q <= '0;
			z_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						phase_q <= t_new;
						arg_q <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (case_a || case_b) begin
						state_q <= ST_DIV;
					end else if (arg_q == 2'd2) begin
						state_q <= ST_COMB;
					end else begin
						arg_q <= arg_q + 2'd1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: state_q <= ST_STORE;
				ST_STORE: begin
					if (arg_q == 2'd2) begin
						state_q <= ST_COMB;
					end else begin
						arg_q <= arg_q + 2'd1;
						state_q <= ST_SETUP;
					end
				end
				ST_COMB: state_q <= ST_TRIMUL;
				ST_TRIMUL: state_q <= ST_TRIACC;
				ST_TRIACC: begin
					if (z_sum > 21'(TRI_MAX)) begin
						z_q <= TRI_MAX;
					end else if (z_sum < 21'(TRI_MIN)) begin
						z_q <= TRI_MIN;
					end else begin
						z_q <= z_sum[17:0];
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			t_q <= t_new;
			d_q <= s_tdata[22:0];
			pw_q <= s_tdata[46:23];
			sel_q <= s_tuser;
		end
		if (state_q == ST_SETUP) begin
			casea_q <= case_a;
			if (!(case_a || case_b)) begin
				b_q[arg_q] <= '0;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			u_q <= casea_q ? (31'(1) << 30) - {1'b0, div_rsp.quot} : {1'b0, div_rsp.quot};
		end
		if (state_q == ST_SQR) begin
			prod_q <= u_q * u_q;
		end
		if (state_q == ST_STORE) begin
			b_q[arg_q] <= casea_q ? -$signed(sq_mag) : $signed(sq_mag);
		end
		if (state_q == ST_COMB) begin
			v_q <= (sel_q == WAVE_SAW) ? saw_w : pulse_w;
			diff_q <= 20'(sq15_w) - 20'(z_q);
		end
		if (state_q == ST_TRIMUL) begin
			tprod_q <= diff_q * $signed({1'b0, d_q});
		end
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= o_fin;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	`ASSERT_IMPL(a_div_start_setup, div_req.start, state_q == ST_SETUP)
	`ASSERT_IMPL(a_div_done_wait, div_rsp.done, state_q == ST_DIV)
	`ASSERT_NEXT(a_accept_to_setup, s_tvalid && s_tready, state_q == ST_SETUP)
	`ASSERT_NEXT(a_finish_loads_out, state_q == ST_FINISH && out_free, m_tvalid)
endmodule
`default_nettype wire

// ----- tb/polyblep_oscillator_chk.sv -----
// ----------------------------------------------------------------------------
// PolyBLEP oscillator checker
// Watches both stream channels. For every input transaction it forms the
// expected sample from its own copy of the phase and integrator state. Each
// output transaction is compared with the oldest expected sample.
// ----------------------------------------------------------------------------
module polyblep_oscillator_chk
	import pblep_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [47:0] s_tdata,
	input logic [1:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q30 = longint'(1) << 30;
	localparam longint PH_ONE = longint'(1) << 24;
	localparam longint PH_HALF = longint'(1) << 23;

	logic signed [15:0] cos_rom [1024];
	logic signed [15:0] samples_due [$];
	longint phase;
	longint tri_acc;

	function automatic longint quarter_cos(int m);
		longint a;
		longint term;
		longint sum;
		a = (longint'(m) * 64'sd6746518852) >>> 10;
		term = ONE_Q30;
		sum = ONE_Q30;
		for (int n = 1; n <= 12; n++) begin
			term = (term * a) >>> 30;
			term = (term * a) >>> 30;
			term = term / longint'((2 * n - 1) * (2 * n));
			if (n % 2) begin
				sum -= term;
			end else begin
				sum += term;
			end
		end
		if (sum < 0) sum = 0;
		if (sum > ONE_Q30) sum = ONE_Q30;
		return (sum * 32767 + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic longint edge_fix(longint t, longint d);
		longint u;
		if (t < d) begin
			u = ONE_Q30 - ((t << 30) / d);
			return -((u * u) >>> 30);
		end
		if (d != 0 && t > PH_ONE - d) begin
			u = ((t - (PH_ONE - d)) << 30) / d;
			return (u * u) >>> 30;
		end
		return 0;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [15:0] next_sample(logic [22:0] inc, logic [23:0] pw,
		logic [1:0] wave);
		longint d;
		longint w;
		longint saw;
		longint pulse;
		longint sq;
		longint v;
		longint o;
		d = longint'(inc);
		w = longint'(pw);
		phase = (phase + d) & (PH_ONE - 1);
		saw = (phase << 7) - ONE_Q30 - edge_fix(phase, d);
		pulse = (phase > w) ? ONE_Q30 : -ONE_Q30;
		pulse = pulse - edge_fix(phase, d) + edge_fix((phase - w) & (PH_ONE - 1), d);
		sq = (phase > PH_HALF) ? ONE_Q30 : -ONE_Q30;
		sq = sq - edge_fix(phase, d) + edge_fix((phase + PH_HALF) & (PH_ONE - 1), d);
		tri_acc += rnd_shift((rnd_shift(sq, 15) - tri_acc) * d, 24);
		if (tri_acc > 131071) tri_acc = 131071;
		if (tri_acc < -131072) tri_acc = -131072;
		case (wave)
			WAVE_SAW: v = saw;
			WAVE_PULSE: v = pulse;
			WAVE_SINE: v = longint'(cos_rom[phase >> 14]) * 32768;
			default: v = tri_acc * 32768;
		endcase
		o = rnd_shift(v, 15);
		if (o > 32767) o = 32767;
		if (o < -32768) o = -32768;
		return 16'(o);
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	initial begin
		for (int i = 0; i < 1024; i++) begin
			case (i / 256)
				0: cos_rom[i] = 16'(quarter_cos(i % 256));
				1: cos_rom[i] = 16'(-quarter_cos(256 - i % 256));
				2: cos_rom[i] = 16'(-quarter_cos(i % 256));
				default: cos_rom[i] = 16'(quarter_cos(256 - i % 256));
			endcase
		end
		phase = 0;
		tri_acc = 0;
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				samples_due.push_back(next_sample(s_tdata[22:0], s_tdata[46:23], s_tuser));
			if (m_tvalid && m_tready) begin
				if (samples_due.size() == 0) begin
					report_mismatch($sformatf("unexpected sample %0d", $signed(m_tdata)));
				end else begin
					want = samples_due.pop_front();
					if (m_tdata !== want)
						report_mismatch($sformatf("sample_out %0d, expected %0d",
							$signed(m_tdata), want));
				end
			end
			pending <= samples_due.size();
		end
	end
endmodule

// ----- tb/polyblep_oscillator_tb.sv -----
// ----------------------------------------------------------------------------
// PolyBLEP oscillator testbench
// Drives directed and random ticks with random gaps and output stalls, and
// takes its verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module polyblep_oscillator_tb
	import pblep_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [15:0] m_tdata;
	int errors;
	int pending;
	int cycles = 0;
	bit calm_tx = 0;
	bit calm_rx = 0;

	polyblep_oscillator u_top (.*);
	polyblep_oscillator_chk u_chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** polyblep_oscillator: FAILED **");
			$finish;
		end
	end

	task automatic send_tick(logic [22:0] inc, logic [23:0] pw, logic [1:0] wave);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {1'b0, pw, inc};
		s_tuser = wave;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	always begin
		int stall;
		@(negedge clk);
		stall = calm_rx ? 0 : $urandom_range(0, 9);
		m_tready = 0;
		repeat (stall) @(negedge clk);
		m_tready = 1;
		do @(posedge clk); while (!m_tvalid);
	end

	initial begin
		logic [22:0] inc;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		for (int w = 0; w < 4; w++) begin
			send_tick(23'd0, 24'h800000, 2'(w));
			send_tick(23'h7FFFFF, 24'h800000, 2'(w));
			send_tick(23'h7FFFFF, 24'd0, 2'(w));
			send_tick(23'd1, 24'hFFFFFF, 2'(w));
		end
		for (int i = 0; i < 6; i++) send_tick(23'd3, 24'h800000, WAVE_TRI);
		send_tick(23'h123457, 24'd0, WAVE_PULSE);
		send_tick(23'h400000, 24'hFFFFFF, WAVE_PULSE);
		send_tick(23'h2AAAAB, 24'h555555, WAVE_SAW);
		for (int i = 0; i < 450; i++) begin
			if (i % 60 == 0) begin
				calm_tx = ($urandom_range(0, 3) == 0);
				calm_rx = ($urandom_range(0, 3) == 0);
			end
			case ($urandom_range(0, 3))
				0: inc = 23'($urandom_range(0, 8388607));
				1: inc = 23'($urandom_range(0, 255));
				default: inc = 23'($urandom_range(0, 300000));
			endcase
			send_tick(inc, 24'($urandom), 2'($urandom));
		end
		s_tvalid = 0;
		while (pending != 0 || u_chk.samples_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("** polyblep_oscillator: PASSED **");
		end else begin
			$display("** polyblep_oscillator: FAILED **");
		end
		$finish;
	end
endmodule
